>>> rtl/greedy_distance_point_thinning_unit_defines.svh
// Assertion macros used by the thinning unit top-level RTL.
`ifndef GREEDY_DISTANCE_POINT_THINNING_UNIT_DEFINES_SVH
`define GREEDY_DISTANCE_POINT_THINNING_UNIT_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define GDPT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define GDPT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gdpt_pkg.sv
package gdpt_pkg;

    // Default sizing
    localparam int KEPT_DEPTH_DEF  = 256;
    localparam int COORD_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int FIELD_W    = 16;
    localparam int INDEX_W    = 16;
    localparam int KCOUNT_W   = 9;
    localparam int DIMS_W     = 2;
    localparam int MIND_W     = 18;
    localparam int THR_W      = 2 * MIND_W;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_DIMENSIONS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = CFG_IDX_W'(1);

    localparam logic [DIMS_W-1:0] DIMS_RESET = DIMS_W'(2);
    localparam logic [DIMS_W-1:0] DIMS_3D    = DIMS_W'(3);

    // Control broadcast from the top level to every cell
    typedef struct packed {
        logic             use_y;
        logic             use_z;
        logic             wr_en;
        logic [THR_W-1:0] thr;
    } ctrl_t;

endpackage

>>> rtl/greedy_distance_point_thinning_unit.sv
// A result is offered once the query has passed the row of KEPT_DEPTH comparison
// cells and been committed; a new point is taken only after that commit. The query
// walks the row one cell per cycle, then waits in the done state until the output is free.
// A new point is taken while the previous result still waits on the output.
// Reset (aresetn low, synchronous): kept count, point index and output valid clear,
// dimensions returns to 2 and min_distance to 0; kept coordinates are not cleared.
module greedy_distance_point_thinning_unit #(
    parameter int KEPT_DEPTH  = gdpt_pkg::KEPT_DEPTH_DEF,
    parameter int COORD_WIDTH = gdpt_pkg::COORD_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input points
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // x_coord[15:0], y_coord[31:16], z_coord[47:32]
    input  logic [gdpt_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tlast,
    // Results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // kept[0], point_index[16:1], kept_count[25:17], overflow[26], zero[31:27]
    output logic [gdpt_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gdpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gdpt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gdpt_pkg::*;
    `include "greedy_distance_point_thinning_unit_defines.svh"

    localparam int CNT_W = $clog2(KEPT_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(KEPT_DEPTH);
    localparam int PAD_W = M_TDATA_W - (1 + INDEX_W + KCOUNT_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [DIMS_W-1:0]   dims_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [MIND_W-1:0]   cfg_mind;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [INDEX_W-1:0]  seen_reg, seen_next;
    logic                close_fin_reg;

    logic signed [COORD_WIDTH-1:0] qx_reg, qy_reg, qz_reg;
    logic                          qlast_reg;
    logic signed [COORD_WIDTH-1:0] px_in, py_in, pz_in;

    logic                m_valid_reg;
    logic                m_kept_reg, m_ovf_reg, m_last_reg;
    logic [INDEX_W-1:0]  m_index_reg;
    logic [KCOUNT_W-1:0] m_count_reg;

    logic  use_y, use_z;
    logic  s_accept, cfg_accept, out_free, commit, qual, has_room;
    ctrl_t ctrl;

    logic                          ch_valid [0:KEPT_DEPTH];
    logic                          ch_close [0:KEPT_DEPTH];
    logic signed [COORD_WIDTH-1:0] ch_x     [0:KEPT_DEPTH];
    logic signed [COORD_WIDTH-1:0] ch_y     [0:KEPT_DEPTH];
    logic signed [COORD_WIDTH-1:0] ch_z     [0:KEPT_DEPTH];

    // Handshakes
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign out_free   = !m_valid_reg || m_tready;
    assign commit     = (state_reg == ST_DONE) && out_free;

    // Dimension decode; zero acts as one
    assign use_y = dims_reg[1];
    assign use_z = (dims_reg == DIMS_3D);

    // Take the low coordinate bits and drop unused axes
    always_comb begin
        px_in = COORD_WIDTH'($signed(s_tdata[FIELD_W-1:0]));
        py_in = use_y ? COORD_WIDTH'($signed(s_tdata[2*FIELD_W-1:FIELD_W])) : '0;
        pz_in = use_z ? COORD_WIDTH'($signed(s_tdata[3*FIELD_W-1:2*FIELD_W])) : '0;
    end

    // Decide and count at commit
    always_comb begin
        qual       = !close_fin_reg;
        has_room   = count_reg < DEPTH_C;
        ctrl.use_y = use_y;
        ctrl.use_z = use_z;
        ctrl.thr   = thr_reg;
        ctrl.wr_en = commit && qual && has_room;
        count_next = ctrl.wr_en ? CNT_W'(count_reg + 1'b1) : count_reg;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (ch_valid[KEPT_DEPTH]) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Point index for the next beat
    always_comb begin
        if (qlast_reg) begin
            seen_next = '0;
        end else if (seen_reg != {INDEX_W{1'b1}}) begin
            seen_next = seen_reg + 1'b1;
        end else begin
            seen_next = seen_reg;
        end
    end

    assign cfg_mind = cfg_data[MIND_W-1:0];

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dims_reg    <= DIMS_RESET;
            thr_reg     <= '0;
            count_reg   <= '0;
            seen_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_accept && (cfg_index == REG_DIMENSIONS)) begin
                dims_reg <= cfg_data[DIMS_W-1:0];
            end
            if (cfg_accept && (cfg_index == REG_MIN_DISTANCE)) begin
                thr_reg <= THR_W'(cfg_mind) * THR_W'(cfg_mind);
            end
            if (commit) begin
                count_reg   <= qlast_reg ? '0 : count_next;
                seen_reg    <= seen_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the query point, catch the row's verdict, load the result
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            qx_reg    <= px_in;
            qy_reg    <= py_in;
            qz_reg    <= pz_in;
            qlast_reg <= s_tlast;
        end
        if ((state_reg == ST_RUN) && ch_valid[KEPT_DEPTH]) begin
            close_fin_reg <= ch_close[KEPT_DEPTH];
        end
        if (commit) begin
            m_kept_reg  <= qual;
            m_ovf_reg   <= qual && !has_room;
            m_index_reg <= seen_reg;
            m_count_reg <= KCOUNT_W'(count_next);
            m_last_reg  <= qlast_reg;
        end
    end

    // Inject the accepted point at the head of the row
    assign ch_valid[0] = s_accept;
    assign ch_close[0] = 1'b0;
    assign ch_x[0]     = px_in;
    assign ch_y[0]     = py_in;
    assign ch_z[0]     = pz_in;

    // Row of kept-point cells
    for (genvar i = 0; i < KEPT_DEPTH; i++) begin : g_cell
        gdpt_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .KEPT_DEPTH  (KEPT_DEPTH),
            .CELL_IDX    (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .count     (count_reg),
            .wr_x      (qx_reg),
            .wr_y      (qy_reg),
            .wr_z      (qz_reg),
            .in_valid  (ch_valid[i]),
            .in_close  (ch_close[i]),
            .in_x      (ch_x[i]),
            .in_y      (ch_y[i]),
            .in_z      (ch_z[i]),
            .out_valid (ch_valid[i+1]),
            .out_close (ch_close[i+1]),
            .out_x     (ch_x[i+1]),
            .out_y     (ch_y[i+1]),
            .out_z     (ch_z[i+1])
        );
    end

    // Result beat
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_ovf_reg, m_count_reg, m_index_reg, m_kept_reg};

    `GDPT_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= DEPTH_C,
        "kept count beyond store depth")
    `GDPT_ASSERT_NOW(a_row_end_in_run, aclk, aresetn, ch_valid[KEPT_DEPTH],
        state_reg == ST_RUN, "query left the row outside the run state")
    `GDPT_ASSERT_NEXT(a_count_stable_run, aclk, aresetn, state_reg == ST_RUN,
        $stable(count_reg), "kept count moved while a query was in the row")
    `GDPT_ASSERT_NEXT(a_accept_starts_run, aclk, aresetn, s_accept,
        state_reg == ST_RUN, "accepted point did not start a run")
    `GDPT_ASSERT_NOW(a_overflow_kept, aclk, aresetn, m_valid_reg && m_ovf_reg,
        m_kept_reg, "overflow reported on a rejected point")

endmodule

>>> rtl/gdpt_cell.sv
module gdpt_cell #(
    parameter int COORD_WIDTH = gdpt_pkg::COORD_WIDTH_DEF,
    parameter int KEPT_DEPTH  = gdpt_pkg::KEPT_DEPTH_DEF,
    parameter int CELL_IDX    = 0,
    localparam int CNT_W      = $clog2(KEPT_DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gdpt_pkg::ctrl_t               ctrl,
    input  logic [CNT_W-1:0]              count,
    input  logic signed [COORD_WIDTH-1:0] wr_x,
    input  logic signed [COORD_WIDTH-1:0] wr_y,
    input  logic signed [COORD_WIDTH-1:0] wr_z,
    input  logic                          in_valid,
    input  logic                          in_close,
    input  logic signed [COORD_WIDTH-1:0] in_x,
    input  logic signed [COORD_WIDTH-1:0] in_y,
    input  logic signed [COORD_WIDTH-1:0] in_z,
    output logic                          out_valid,
    output logic                          out_close,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic signed [COORD_WIDTH-1:0] out_z
);
    import gdpt_pkg::*;

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int SQ_W   = 2 * COORD_WIDTH;
    localparam int SUM_W  = SQ_W + 2;
    localparam int CMP_W  = (SUM_W > THR_W) ? SUM_W : THR_W;

    logic signed [COORD_WIDTH-1:0] kx_reg, ky_reg, kz_reg;
    logic signed [COORD_WIDTH-1:0] px_reg, py_reg, pz_reg;
    logic                          valid_reg;
    logic                          close_reg;
    logic [SQ_W-1:0]               sqx_reg, sqy_reg, sqz_reg;
    logic [SQ_W-1:0]               sqx_next, sqy_next, sqz_next;
    logic [SUM_W-1:0]              sq_sum;
    logic                          active;
    logic                          near;

    // Squared difference of one coordinate pair
    function automatic logic [SQ_W-1:0] sq_diff(input logic signed [COORD_WIDTH-1:0] a,
                                                 input logic signed [COORD_WIDTH-1:0] b);
        logic signed [DIFF_W-1:0] d;
        logic [DIFF_W-1:0]        m;
        logic [2*DIFF_W-1:0]      p;
        d = DIFF_W'(a) - DIFF_W'(b);
        m = d[DIFF_W-1] ? $unsigned(-d) : $unsigned(d);
        p = m * m;
        return p[SQ_W-1:0];
    endfunction

    // Square the differences against the held point
    always_comb begin
        sqx_next = sq_diff(in_x, kx_reg);
        sqy_next = ctrl.use_y ? sq_diff(in_y, ky_reg) : '0;
        sqz_next = ctrl.use_z ? sq_diff(in_z, kz_reg) : '0;
    end

    // Sum and compare against the threshold, merge into the close flag
    always_comb begin
        sq_sum    = SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
        active    = CNT_W'(CELL_IDX) < count;
        near      = active && (CMP_W'(sq_sum) < CMP_W'(ctrl.thr));
        out_close = close_reg | near;
        out_valid = valid_reg;
        out_x     = px_reg;
        out_y     = py_reg;
        out_z     = pz_reg;
    end

    // Beat-valid marker travelling along the row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_valid;
        end
    end

    // Advance the query point and its partial result
    always_ff @(posedge aclk) begin
        close_reg <= in_close;
        px_reg    <= in_x;
        py_reg    <= in_y;
        pz_reg    <= in_z;
        sqx_reg   <= sqx_next;
        sqy_reg   <= sqy_next;
        sqz_reg   <= sqz_next;
    end

    // Hold the kept point; load it when this slot is next to fill
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en && (count == CNT_W'(CELL_IDX))) begin
            kx_reg <= wr_x;
            ky_reg <= wr_y;
            kz_reg <= wr_z;
        end
    end

endmodule
